>>> hdl/matrix_inverse_3x3_top_defines.svh
// Assertion macros shared by the matrix inverse RTL.
// No dependencies.
`ifndef MATRIX_INVERSE_3X3_TOP_DEFINES_SVH
`define MATRIX_INVERSE_3X3_TOP_DEFINES_SVH
// Implication checked at every rising clock edge outside reset.
`define MI_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// Implication checked in the next cycle.
`define MI_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`endif

>>> hdl/mi3_pkg.sv
// Types, constants and helpers for the 3x3 matrix inverse pipeline.
// No dependencies.
package mi3_pkg;
  localparam int FRAC_BITS = 16;
  localparam int EW = 32;          // entry width
  localparam int CW = 65;          // cofactor width (exact)
  localparam int DW = 97;          // determinant width (exact)
  localparam int NW = CW + 2 * FRAC_BITS + 1; // dividend magnitude width
  localparam int QW = 33;          // quotient bits kept (rest saturates)
  localparam int NLANE = 9;

  typedef struct packed {
    logic signed [EW-1:0] a_r0c0;
    logic signed [EW-1:0] a_r0c1;
    logic signed [EW-1:0] a_r0c2;
    logic signed [EW-1:0] a_r1c0;
    logic signed [EW-1:0] a_r1c1;
    logic signed [EW-1:0] a_r1c2;
    logic signed [EW-1:0] a_r2c0;
    logic signed [EW-1:0] a_r2c1;
    logic signed [EW-1:0] a_r2c2;
  } mat_in_t;

  typedef struct packed {
    logic signed [EW-1:0] inv_r0c0;
    logic signed [EW-1:0] inv_r0c1;
    logic signed [EW-1:0] inv_r0c2;
    logic signed [EW-1:0] inv_r1c0;
    logic signed [EW-1:0] inv_r1c1;
    logic signed [EW-1:0] inv_r1c2;
    logic signed [EW-1:0] inv_r2c0;
    logic signed [EW-1:0] inv_r2c1;
    logic signed [EW-1:0] inv_r2c2;
    logic                 singular;
  } mat_out_t;

  typedef logic signed [CW-1:0] cof_t;
  typedef logic [NW-1:0] mag_t;
endpackage

>>> hdl/mi3_cofactor.sv
// Cofactor and determinant stages of the inverse pipeline.
// Depends on mi3_pkg.
module mi3_cofactor (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  input  mi3_pkg::mat_in_t       mat,
  output logic                   out_valid,
  output mi3_pkg::cof_t [8:0]    cof,
  output logic [mi3_pkg::DW-1:0] det_mag,
  output logic                   det_neg,
  output logic                   det_zero
);
  logic signed [31:0] e [9];
  logic signed [63:0] p [18];
  logic signed [63:0] p_r [18];
  logic v1, v2, v3, v4, v5;
  mi3_pkg::cof_t c_r [9];
  mi3_pkg::cof_t c_r2 [9];
  mi3_pkg::cof_t c_r3 [9];
  logic signed [31:0] a0 [3];
  logic signed [31:0] a0_r [3];
  logic signed [64:0] pp_hi [3];
  logic signed [64:0] pp_lo [3];
  logic signed [64:0] pp_hi_r [3];
  logic signed [64:0] pp_lo_r [3];
  logic signed [96:0] dsum;
  logic signed [96:0] dsum_r;

  assign e = '{mat.a_r0c0, mat.a_r0c1, mat.a_r0c2, mat.a_r1c0, mat.a_r1c1,
               mat.a_r1c2, mat.a_r2c0, mat.a_r2c1, mat.a_r2c2};

  // Index pairs per cofactor, e[i0]*e[i1] - e[i2]*e[i3].
  always_comb begin
    p[0]  = e[4] * e[8]; p[1]  = e[5] * e[7];
    p[2]  = e[2] * e[7]; p[3]  = e[1] * e[8];
    p[4]  = e[1] * e[5]; p[5]  = e[2] * e[4];
    p[6]  = e[5] * e[6]; p[7]  = e[3] * e[8];
    p[8]  = e[0] * e[8]; p[9]  = e[2] * e[6];
    p[10] = e[2] * e[3]; p[11] = e[0] * e[5];
    p[12] = e[3] * e[7]; p[13] = e[4] * e[6];
    p[14] = e[1] * e[6]; p[15] = e[0] * e[7];
    p[16] = e[0] * e[4]; p[17] = e[1] * e[3];
  end

  // Each first-column cofactor is split at bit 32, so every determinant
  // product is a signed 33 by 32 bit multiply.
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      pp_hi[k] = 65'($signed(c_r[3*k][64:32])) * 65'(a0[k]);
      pp_lo[k] = 65'($signed({1'b0, c_r[3*k][31:0]})) * 65'(a0[k]);
    end
  end

  always_comb begin
    dsum = '0;
    for (int k = 0; k < 3; k++) begin
      dsum = dsum + $signed({pp_hi_r[k], 32'h0}) + 97'(pp_lo_r[k]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
    end else begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      v5 <= v4;
    end
    p_r <= p;
    a0_r <= '{e[0], e[1], e[2]};
    for (int i = 0; i < 9; i++) begin
      c_r[i] <= 65'(p_r[2*i]) - 65'(p_r[2*i+1]);
    end
    a0 <= a0_r;
    c_r2 <= c_r;
    pp_hi_r <= pp_hi;
    pp_lo_r <= pp_lo;
    c_r3 <= c_r2;
    dsum_r <= dsum;
    for (int i = 0; i < 9; i++) begin
      cof[i] <= c_r3[i];
    end
    det_mag <= dsum_r[96] ? 97'(-dsum_r) : 97'(dsum_r);
    det_neg <= dsum_r[96];
    det_zero <= (dsum_r == '0);
  end

  assign out_valid = v5;
endmodule

>>> hdl/mi3_divider.sv
// Pipelined restoring divider, one quotient bit per stage, with rounding
// and saturation. Depends on mi3_pkg.
module mi3_divider (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  input  mi3_pkg::cof_t          cof,
  input  logic [mi3_pkg::DW-1:0] det_mag,
  input  logic                   det_neg,
  output logic                   out_valid,
  output logic signed [31:0]     quo
);
  localparam int QW = mi3_pkg::QW;
  localparam int RW = mi3_pkg::DW + 2;
  // Quotient bits at or above QW only mean saturation; a high-part
  // compare catches them.
  logic [QW:0] vld;
  logic [RW-1:0] rem [QW+1];
  logic [RW-1:0] dvs [QW+1];
  logic [mi3_pkg::NW-1:0] num [QW+1];
  logic [QW-1:0] q [QW+1];
  logic neg [QW+1];
  logic sat [QW+1];
  logic [mi3_pkg::CW-1:0] cmag;
  logic [mi3_pkg::NW-1:0] n0;
  logic [RW+QW-1:0] hi_full;
  logic [RW-1:0] d2;

  always_comb begin
    cmag = cof[mi3_pkg::CW-1] ? mi3_pkg::CW'(-cof) : mi3_pkg::CW'(cof);
    n0 = ({1'b0, cmag, {(2*mi3_pkg::FRAC_BITS){1'b0}}} << 1)
         + mi3_pkg::NW'(det_mag);
    d2 = {det_mag, 1'b0};
    hi_full = (RW+QW)'(n0);
  end

  always_ff @(posedge clk) begin
    if (rst) vld <= '0;
    else vld <= {vld[QW-1:0], in_valid};
    // Saturate when n >= d2 * 2^QW.
    sat[0] <= (hi_full >> QW) >= (RW+QW)'(d2);
    // Remainder starts from the bits above QW, loaded at stage 0.
    rem[0] <= RW'(n0 >> QW);
    num[0] <= n0;
    dvs[0] <= d2;
    q[0] <= '0;
    neg[0] <= cof[mi3_pkg::CW-1] ^ det_neg;
    for (int s = 0; s < QW; s++) begin
      logic [RW:0] r2;
      r2 = {rem[s], num[s][QW-1-s]};
      if (r2 >= {1'b0, dvs[s]}) begin
        rem[s+1] <= RW'(r2 - {1'b0, dvs[s]});
        q[s+1] <= {q[s][QW-2:0], 1'b1};
      end else begin
        rem[s+1] <= RW'(r2);
        q[s+1] <= {q[s][QW-2:0], 1'b0};
      end
      num[s+1] <= num[s];
      dvs[s+1] <= dvs[s];
      neg[s+1] <= neg[s];
      sat[s+1] <= sat[s];
    end
  end

  always_comb begin
    logic big;
    big = sat[QW] || (q[QW] >= 33'h80000000);
    if (neg[QW]) quo = big ? 32'sh80000000 : 32'(-q[QW]);
    else quo = (sat[QW] || q[QW] >= 33'h7FFFFFFF) ? 32'sh7FFFFFFF : 32'(q[QW]);
  end

  assign out_valid = vld[QW];
endmodule

>>> hdl/matrix_inverse_3x3_top.sv
// Top level of the 3x3 matrix inverse pipeline.
// Depends on mi3_pkg, mi3_cofactor, mi3_divider and the defines header.
`include "matrix_inverse_3x3_top_defines.svh"
// Fully pipelined: one matrix transfer per clock, busy is always low after
// reset. A result passes through five cofactor and determinant stages, the
// 34 stages of the bit-per-stage divider lanes (nine lanes in parallel)
// and the output register. The result sits on the ports for one cycle with
// done high; the receiver cannot stall it. When the determinant is exactly
// zero, singular is set and all entries are 0. Entries beyond the 32-bit
// range saturate; rounding is to nearest, ties away from zero.
module matrix_inverse_3x3_top (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  mi3_pkg::mat_in_t  mat_in,
  output logic              done,
  output mi3_pkg::mat_out_t mat_out
);
  localparam int QW = mi3_pkg::QW;
  logic cv;
  mi3_pkg::cof_t [8:0] cof;
  logic [mi3_pkg::DW-1:0] det_mag;
  logic det_neg, det_zero;
  logic [8:0] dv;
  logic signed [31:0] q [9];
  logic [QW:0] zero_dly;

  assign busy = 1'b0;

  mi3_cofactor u_cof (
    .clk(clk), .rst(rst), .in_valid(start & ~busy), .mat(mat_in),
    .out_valid(cv), .cof(cof), .det_mag(det_mag), .det_neg(det_neg),
    .det_zero(det_zero)
  );

  for (genvar i = 0; i < 9; i++) begin : g_lane
    mi3_divider u_div (
      .clk(clk), .rst(rst), .in_valid(cv), .cof(cof[i]),
      .det_mag(det_zero ? {{(mi3_pkg::DW-1){1'b0}}, 1'b1} : det_mag),
      .det_neg(det_neg), .out_valid(dv[i]), .quo(q[i])
    );
  end

  // The singular flag rides alongside the divider lanes, one bit per stage.
  always_ff @(posedge clk) begin
    zero_dly <= {zero_dly[QW-1:0], det_zero};
    if (rst) done <= 1'b0;
    else done <= dv[0];
    mat_out.singular <= zero_dly[QW];
    mat_out.inv_r0c0 <= zero_dly[QW] ? '0 : q[0];
    mat_out.inv_r0c1 <= zero_dly[QW] ? '0 : q[1];
    mat_out.inv_r0c2 <= zero_dly[QW] ? '0 : q[2];
    mat_out.inv_r1c0 <= zero_dly[QW] ? '0 : q[3];
    mat_out.inv_r1c1 <= zero_dly[QW] ? '0 : q[4];
    mat_out.inv_r1c2 <= zero_dly[QW] ? '0 : q[5];
    mat_out.inv_r2c0 <= zero_dly[QW] ? '0 : q[6];
    mat_out.inv_r2c1 <= zero_dly[QW] ? '0 : q[7];
    mat_out.inv_r2c2 <= zero_dly[QW] ? '0 : q[8];
  end

  `MI_ASSERT_IMPL(a_lanes_agree, dv[0], dv == 9'h1FF, "divider lanes out of step")
  `MI_ASSERT_NEXT(a_done_follows, dv[0], done, "lane result did not reach done")
  `MI_ASSERT_IMPL(a_sing_zero, done && mat_out.singular, mat_out.inv_r0c0 == 0,
    "singular result has nonzero entry")
endmodule
